// File: src/srr_pkg.sv
// Shared constants and types for the selective repeat receiver.
// No dependencies; imported by srr_csum and selective_repeat_receiver.
`timescale 1ns / 1ps
package srr_pkg;

  localparam int MaxWindow    = 16;
  localparam int PayBytes     = 20;
  localparam int BytesPerStep = 4;
  localparam int CsumSteps    = PayBytes / BytesPerStep;
  localparam int PayW         = 8 * PayBytes;
  localparam int SeqW         = 31;
  localparam int WordW        = 32;
  localparam int WinCfgW      = 5;
  localparam logic [WinCfgW-1:0] WinReset = 5'd8;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] sum;
  } csum_res_t;

endpackage

// File: src/srr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module srr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/srr_csum.sv
// Iterative packet checksum: seq plus ack plus signed payload bytes up to the first NUL.
// Uses srr_pkg; processes BytesPerStep bytes per cycle.
`timescale 1ns / 1ps
module srr_csum
  import srr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SeqW-1:0]  seq_i,
  input  logic [WordW-1:0] ack_i,
  input  logic [PayW-1:0]  pay_i,
  output csum_res_t        res_o
);

  localparam int CntW  = $clog2(CsumSteps + 1);
  localparam int StepW = 8 * BytesPerStep;

  logic             busy_q, busy_d;
  logic             stop_q, stop_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] sum_q, sum_d;
  logic [StepW-1:0] word;

  assign word = pay_i[StepW * cnt_q +: StepW];

  always_comb begin
    busy_d = busy_q;
    stop_d = stop_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      stop_d = 1'b0;
      cnt_d  = '0;
      sum_d  = WordW'(seq_i) + ack_i;
    end else if (busy_q) begin
      for (int j = 0; j < BytesPerStep; j++) begin
        if (!stop_d && word[8*j +: 8] != 8'd0) begin
          sum_d = sum_d + {{(WordW-8){word[8*j+7]}}, word[8*j +: 8]};
        end else begin
          stop_d = 1'b1;
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CsumSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      stop_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      stop_q <= stop_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign res_o.done = done_q;
  assign res_o.sum  = sum_q;

endmodule

// File: src/selective_repeat_receiver.sv
// Selective repeat ARQ receiver: checksum, windowed buffering, in-order delivery.
// Uses srr_pkg, srr_csum and srr_ram (payload buffer).
//
//  channel | signals                               | direction
//  in      | in_valid_i / in_ready_o, packet fields | packet transactions in
//  out     | out_valid_o / out_ready_i, result     | ack or delivery transactions out
//  cfg     | cfg_valid_i / cfg_ready_o, window_size | window size write
//
// A packet passes through the idle (accept), checksum and decision states.
// An ack adds an ack state; each delivery adds a buffer read state, then an output load state.
// Corrupt packets and packets above the window return to idle after the decision state with no transaction.
// Output stalls hold the sequencer; a new packet is taken while the last result waits.
// Reset clears base, valid bits and window size (8); the buffer needs no clearing.
`timescale 1ns / 1ps
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int MAX_WINDOW = MaxWindow
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SeqW-1:0]    seq_num_i,
  input  logic [WordW-1:0]   ack_num_i,
  input  logic [WordW-1:0]   check_value_i,
  input  logic [63:0]        payload_low_i,
  input  logic [63:0]        payload_mid_i,
  input  logic [31:0]        payload_high_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [WinCfgW-1:0] window_size_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [SeqW-1:0]    ack_seq_o,
  output logic [63:0]        out_payload_low_o,
  output logic [63:0]        out_payload_mid_o,
  output logic [31:0]        out_payload_high_o,
  output logic               last_o
);

  localparam int SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int StepW = $clog2(MAX_WINDOW + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSum  = 3'd1;
  localparam logic [2:0] StDec  = 3'd2;
  localparam logic [2:0] StAck  = 3'd3;
  localparam logic [2:0] StRd   = 3'd4;
  localparam logic [2:0] StDlv  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [WinCfgW-1:0]    wsize_q;
  logic [SeqW-1:0]       base_q, base_d;
  logic [SlotW-1:0]      base_slot_q, base_slot_d;
  logic [MAX_WINDOW-1:0] valid_q, valid_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  store_q, store_d;
  logic [SeqW-1:0]       seq_q;
  logic [WordW-1:0]      chk_q;
  logic [PayW-1:0]       pay_q;

  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, last_q;
  logic [SeqW-1:0]       ack_seq_q;
  logic [PayW-1:0]       out_pay_q;
  logic                  load_ack, load_dlv, out_last;

  logic                  in_acc;
  csum_res_t             csum;
  logic [StepW-1:0]      win;
  logic [WordW-1:0]      diff;
  logic                  ge_base, in_win;
  logic [SlotW:0]        slot_sum;
  logic [SlotW-1:0]      slot;
  logic [SlotW-1:0]      next_slot;
  logic [MAX_WINDOW-1:0] valid_after;
  logic                  ram_we, ram_re;
  logic [PayW-1:0]       ram_rdata;
  logic                  out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  srr_csum u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .seq_i  (seq_num_i),
    .ack_i  (ack_num_i),
    .pay_i  (pay_q),
    .res_o  (csum)
  );

  srr_ram #(
    .Width(PayW),
    .Depth(MAX_WINDOW)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot),
    .wdata_i(pay_q),
    .re_i   (ram_re),
    .raddr_i(base_slot_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (32'(wsize_q) > 32'(MAX_WINDOW)) begin
      win = StepW'(MAX_WINDOW);
    end else begin
      win = StepW'(wsize_q);
    end
  end

  assign diff     = {1'b0, seq_q} - {1'b0, base_q};
  assign ge_base  = seq_q >= base_q;
  assign in_win   = ge_base && (diff < 32'(win));
  assign slot_sum = {1'b0, base_slot_q} + {1'b0, diff[SlotW-1:0]};
  assign slot     = (slot_sum >= (SlotW+1)'(MAX_WINDOW)) ?
                    SlotW'(slot_sum - (SlotW+1)'(MAX_WINDOW)) : SlotW'(slot_sum);

  always_comb begin
    if (&base_q) begin
      next_slot = '0;
    end else if (base_slot_q == SlotW'(MAX_WINDOW - 1)) begin
      next_slot = '0;
    end else begin
      next_slot = base_slot_q + 1'b1;
    end
  end

  always_comb begin
    valid_after              = valid_q;
    valid_after[base_slot_q] = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    base_slot_d = base_slot_q;
    valid_d     = valid_q;
    step_d      = step_q;
    store_d     = store_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load_ack    = 1'b0;
    load_dlv    = 1'b0;
    out_last    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StSum;
        end
      end
      StSum: begin
        if (csum.done) begin
          state_d = StDec;
        end
      end
      StDec: begin
        store_d = 1'b0;
        state_d = StIdle;
        if (csum.sum == chk_q) begin
          if (in_win && !valid_q[slot]) begin
            store_d       = 1'b1;
            ram_we        = 1'b1;
            valid_d[slot] = 1'b1;
            state_d       = StAck;
          end else if (!ge_base || in_win) begin
            state_d = StAck;
          end
        end
      end
      StAck: begin
        if (out_free) begin
          load_ack = 1'b1;
          step_d   = '0;
          out_last = !store_q || !valid_q[base_slot_q];
          state_d  = out_last ? StIdle : StRd;
        end
      end
      StRd: begin
        ram_re  = 1'b1;
        state_d = StDlv;
      end
      StDlv: begin
        if (out_free) begin
          load_dlv    = 1'b1;
          valid_d     = valid_after;
          base_d      = base_q + 1'b1;
          base_slot_d = next_slot;
          step_d      = step_q + 1'b1;
          out_last    = (step_q + 1'b1 == win) || !valid_after[next_slot];
          state_d     = out_last ? StIdle : StRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = load_ack || load_dlv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wsize_q     <= WinReset;
      base_q      <= '0;
      base_slot_q <= '0;
      valid_q     <= '0;
      step_q      <= '0;
      store_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      base_slot_q <= base_slot_d;
      valid_q     <= valid_d;
      step_q      <= step_d;
      store_q     <= store_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        wsize_q <= window_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q <= seq_num_i;
      chk_q <= check_value_i;
      pay_q <= {payload_high_i, payload_mid_i, payload_low_i};
    end
    if (load_ack) begin
      kind_q    <= 1'b0;
      ack_seq_q <= seq_q;
      out_pay_q <= '0;
      last_q    <= out_last;
    end else if (load_dlv) begin
      kind_q    <= 1'b1;
      ack_seq_q <= '0;
      out_pay_q <= ram_rdata;
      last_q    <= out_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign ack_seq_o          = ack_seq_q;
  assign out_payload_low_o  = out_pay_q[63:0];
  assign out_payload_mid_o  = out_pay_q[127:64];
  assign out_payload_high_o = out_pay_q[PayW-1:128];
  assign last_o             = last_q;

  a_dlv_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDlv) |-> valid_q[base_slot_q])
    else $error("delivery from an empty slot");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |-> (step_q < win))
    else $error("drain exceeded the window");

  a_accept_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StSum))
    else $error("accepted packet did not start the checksum");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_ack || load_dlv) |-> out_free)
    else $error("result overwrote a pending transaction");

endmodule

// File: tb/selective_repeat_receiver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for selective_repeat_receiver: random packet, result and
// window-size traffic, each ack and delivery checked against an in-bench window model.
// Depends on srr_pkg and the selective_repeat_receiver RTL.
module selective_repeat_receiver_tb;
  import srr_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 24;

  typedef enum logic {RES_ACK = 1'b0, RES_DELIVERY = 1'b1} res_kind_e;

  typedef struct packed {
    res_kind_e       kind;
    logic [SeqW-1:0] ack_seq;
    logic [PayW-1:0] payload;
    logic            last;
  } srr_result_t;

  class arq_scoreboard;
    logic [SeqW-1:0]    base;
    logic [WinCfgW-1:0] win_cfg;
    bit                 held[MaxWindow];
    logic [PayW-1:0]    buffered[MaxWindow];
    srr_result_t        due_results[$];
    int                 errors;
    int                 acks;
    int                 deliveries;
    int                 longest_burst;

    function new();
      base          = '0;
      win_cfg       = WinReset;
      errors        = 0;
      acks          = 0;
      deliveries    = 0;
      longest_burst = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void set_window(logic [WinCfgW-1:0] w);
      win_cfg = w;
    endfunction

    function int unsigned effective_window();
      return (win_cfg > MaxWindow) ? MaxWindow : win_cfg;
    endfunction

    function logic [WordW-1:0] packet_sum(logic [SeqW-1:0] seq, logic [WordW-1:0] ack,
                                          logic [PayW-1:0] pay);
      logic [WordW-1:0] sum;
      logic [7:0]       b;
      sum = {1'b0, seq} + ack;
      for (int i = 0; i < PayBytes; i++) begin
        b = pay[8*i +: 8];
        if (b == 8'h00) break;
        sum = sum + {{(WordW-8){b[7]}}, b};
      end
      return sum;
    endfunction

    function void note_packet(logic [SeqW-1:0] seq, logic [WordW-1:0] ack,
                              logic [WordW-1:0] chk, logic [PayW-1:0] pay);
      srr_result_t     burst[$];
      longint unsigned win_end;
      int unsigned     win;
      int              slot;
      win     = effective_window();
      win_end = base;
      win_end = win_end + win;
      slot    = seq % MaxWindow;
      if (packet_sum(seq, ack, pay) != chk) return;
      if (seq >= base && seq < win_end && !held[slot]) begin
        burst.insert(burst.size(), '{RES_ACK, seq, '0, 1'b0});
        held[slot]     = 1'b1;
        buffered[slot] = pay;
        for (int unsigned s = 0; s < win; s++) begin
          if (!held[base % MaxWindow]) break;
          burst.insert(burst.size(), '{RES_DELIVERY, '0, buffered[base % MaxWindow], 1'b0});
          held[base % MaxWindow] = 1'b0;
          base = base + 1'b1;
        end
      end else if (seq < win_end) begin
        burst.insert(burst.size(), '{RES_ACK, seq, '0, 1'b0});
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      if (burst.size() > longest_burst) longest_burst = burst.size();
      foreach (burst[i]) due_results.insert(due_results.size(), burst[i]);
    endfunction

    function void field_check(string name, logic [PayW-1:0] want, logic [PayW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(srr_result_t r);
      srr_result_t want;
      if (r.kind == RES_ACK) acks++;
      else deliveries++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual kind %0d ack_seq %h last %0b",
                 $time, r.kind, r.ack_seq, r.last);
        return;
      end
      want = due_results.pop_front();
      field_check("kind", PayW'(want.kind), PayW'(r.kind));
      field_check("ack_seq", PayW'(want.ack_seq), PayW'(r.ack_seq));
      field_check("payload", want.payload, r.payload);
      field_check("last", PayW'(want.last), PayW'(r.last));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SeqW-1:0]    seq_num_i;
  logic [WordW-1:0]   ack_num_i;
  logic [WordW-1:0]   check_value_i;
  logic [63:0]        payload_low_i;
  logic [63:0]        payload_mid_i;
  logic [31:0]        payload_high_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [WinCfgW-1:0] window_size_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               kind_o;
  logic [SeqW-1:0]    ack_seq_o;
  logic [63:0]        out_payload_low_o;
  logic [63:0]        out_payload_mid_o;
  logic [31:0]        out_payload_high_o;
  logic               last_o;

  arq_scoreboard sb = new();
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            packets_sent   = 0;
  int            corrupt_sent   = 0;
  int            idle_cycles    = 0;

  selective_repeat_receiver dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .seq_num_i          (seq_num_i),
    .ack_num_i          (ack_num_i),
    .check_value_i      (check_value_i),
    .payload_low_i      (payload_low_i),
    .payload_mid_i      (payload_mid_i),
    .payload_high_i     (payload_high_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .window_size_i      (window_size_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .ack_seq_o          (ack_seq_o),
    .out_payload_low_o  (out_payload_low_o),
    .out_payload_mid_o  (out_payload_mid_o),
    .out_payload_high_o (out_payload_high_o),
    .last_o             (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{res_kind_e'(kind_o), ack_seq_o,
                        {out_payload_high_o, out_payload_mid_o, out_payload_low_o}, last_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [PayW-1:0] rand_payload();
    logic [PayW-1:0] p;
    for (int i = 0; i < PayBytes; i++) begin
      p[8*i +: 8] = ($urandom_range(11) == 0) ? 8'h00 : 8'($urandom());
    end
    return p;
  endfunction

  task automatic send_packet(input logic [SeqW-1:0] seq, input logic [WordW-1:0] ack,
                             input logic [PayW-1:0] pay, input bit corrupt);
    logic [WordW-1:0] chk;
    chk = sb.packet_sum(seq, ack, pay);
    if (corrupt) chk = chk ^ (32'h1 << $urandom_range(WordW-1));
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    seq_num_i      <= seq;
    ack_num_i      <= ack;
    check_value_i  <= chk;
    payload_low_i  <= pay[63:0];
    payload_mid_i  <= pay[127:64];
    payload_high_i <= pay[159:128];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_packet(seq, ack, chk, pay);
    packets_sent++;
    if (corrupt) corrupt_sent++;
  endtask

  // hold off until every expected transaction is out and the block has settled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WinCfgW-1:0] w);
    wait_drained();
    cfg_valid_i   <= 1'b1;
    window_size_i <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_window(w);
    cfg_valid_i <= 1'b0;
  endtask

  // fill the current window in shuffled order, with corrupt, stale and far-off noise
  task automatic run_random(input int unsigned target);
    logic [SeqW-1:0] order[$];
    logic [SeqW-1:0] tmp;
    int unsigned     w;
    int unsigned     j;
    int unsigned     roll;
    int unsigned     sent;
    sent = 0;
    while (sent < target) begin
      w = sb.effective_window();
      order.delete();
      for (int unsigned k = 0; k < w; k++) order.insert(order.size(), SeqW'(sb.base + k));
      for (int k = order.size() - 1; k > 0; k--) begin
        j        = $urandom_range(k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      foreach (order[k]) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          send_packet(order[k], $urandom(), rand_payload(), 1'b1);
        end else if (roll < 18) begin
          send_packet(SeqW'(sb.base - $urandom_range(sb.base < 20 ? sb.base : 20)),
                      $urandom(), rand_payload(), 1'b0);
        end else if (roll < 23) begin
          send_packet(SeqW'(sb.base + w + $urandom_range(40)), $urandom(), rand_payload(),
                      1'b0);
        end else if (roll < 26) begin
          send_packet(SeqW'($urandom()), $urandom(), rand_payload(), 1'($urandom_range(1)));
        end
        send_packet(order[k], $urandom(), rand_payload(), 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    seq_num_i      = '0;
    ack_num_i      = '0;
    check_value_i  = '0;
    payload_low_i  = '0;
    payload_mid_i  = '0;
    payload_high_i = '0;
    cfg_valid_i    = 1'b0;
    window_size_i  = '0;
    out_ready_i    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 22;
    recv_stall_pct = 60;
    send_packet(0, 32'h0000_0000, {PayBytes{8'hFF}}, 1'b0);
    send_packet(2, 32'h1234_5678, rand_payload() & ~160'hFF, 1'b0);
    send_packet(1, 32'h8000_0000, {PayBytes{8'h80}}, 1'b0);
    send_packet(3, $urandom(), rand_payload(), 1'b1);
    send_packet(11, $urandom(), rand_payload(), 1'b0);
    send_packet(10, $urandom(), rand_payload(), 1'b0);
    send_packet(31'h7FFF_FFFF, 32'h7FFF_FFFF, {PayBytes{8'h7F}}, 1'b0);
    send_packet(3, 32'hFFFF_FFFF, rand_payload(), 1'b0);
    send_packet(10, $urandom(), rand_payload(), 1'b0);

    // zero window: only packets below the base get acked
    write_window(5'd0);
    send_packet(3, $urandom(), rand_payload(), 1'b0);
    send_packet(4, $urandom(), rand_payload(), 1'b0);

    // oversized window acts as full width; the base packet drains all sixteen slots
    write_window(5'd31);
    for (int k = 19; k >= 5; k--) send_packet(SeqW'(k), $urandom(), rand_payload(), 1'b0);
    send_packet(4, $urandom(), rand_payload(), 1'b0);

    write_window(5'd1);
    run_random(8);
    write_window(WinReset);
    run_random(16);

    send_idle_pct  = 60;
    recv_stall_pct = 22;
    write_window(5'd16);
    run_random(16);
    write_window(5'($urandom_range(2, 15)));
    run_random(8);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_window(5'd20);
    run_random(16);

    wait_drained();
    $display("run: %0d packets (%0d corrupt), %0d acks, %0d deliveries, longest burst %0d",
             packets_sent, corrupt_sent, sb.acks, sb.deliveries, sb.longest_burst);
    $display("run: windows 0, 1, 8, 16, 20, 31 and one random size under three stall mixes");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: selective_repeat_receiver.f
src/srr_pkg.sv
src/srr_ram.sv
src/srr_csum.sv
src/selective_repeat_receiver.sv
tb/selective_repeat_receiver_tb.sv
